// File: design/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types, opcodes and constants for the token-bucket frame pacer.
// ----------------------------------------------------------------------------
package frp_pkg;

    localparam int TICK_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int CAP_SHIFT     = 2;
    localparam int CREDIT_BITS   = 26;
    localparam int INTERVAL_BITS = 24;
    localparam int SUM_BITS      = TICK_BITS + FRAC_BITS + 1;

    localparam int OP_BITS       = 3;
    localparam int IN_BYTES      = (OP_BITS + 32 + 7) / 8;
    localparam int IN_DATA_BITS  = IN_BYTES * 8;
    localparam int OUT_DATA_BITS = 8;

    typedef logic [TICK_BITS-1:0]     tick_t;
    typedef logic [CREDIT_BITS-1:0]   credit_t;
    typedef logic [INTERVAL_BITS-1:0] interval_t;
    typedef logic [SUM_BITS-1:0]      sum_t;
    typedef logic [OP_BITS-1:0]       opcode_t;

    localparam opcode_t OP_BEGIN = 3'd0;
    localparam opcode_t OP_END   = 3'd1;
    localparam opcode_t OP_FORCE = 3'd2;
    localparam opcode_t OP_OPEN  = 3'd3;
    localparam opcode_t OP_CLOSE = 3'd4;

    localparam logic REG_FRAME_INTERVAL = 1'b0;
    localparam logic REG_LIMIT_ENABLE   = 1'b1;

    localparam interval_t FRAME_INTERVAL_RESET = 24'd382293;
    localparam sum_t      UNIT_INTERVAL        = sum_t'(1) << FRAC_BITS;

endpackage

// File: design/frame_rate_pacer.sv
// ----------------------------------------------------------------------------
// frame_rate_pacer
// Token-bucket frame pacer: grants or refuses begin-frame requests.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one control event per transfer: an opcode
//   and the current tick count. Master channel m_axis returns one transfer
//   per event holding render_granted (always 0 for opcodes other than begin).
//   cfg_wr_en/cfg_index/cfg_wdata write frame_interval (index 0, 8.16
//   ticks per frame) and limit_enable (index 1); write only while idle.
// Pipeline:
//   An accepted event lands in an input register; when the result register
//   may advance, the pacing logic (one add, a cap compare, an interval compare
//   and subtract) updates the state and loads the result register that drives
//   m_axis_tvalid. One event is taken every cycle while m_axis_tready is high.
// Reset:
//   rst_n clears both registers' valid flags, the pacing state and the grant
//   flag, sets the force flag and loads the configuration reset values.
// Stall:
//   While m_axis_tready is low the result holds, one further event may wait
//   in the input register, and s_axis_tready then falls.
// ----------------------------------------------------------------------------
module frame_rate_pacer
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] opcode, [34:3] now_tick, [39:35] zero
    input  logic [frp_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] render_granted, [7:1] zero
    output logic [frp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,

    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [frp_pkg::INTERVAL_BITS-1:0] cfg_wdata
);

    logic                 in_valid_reg;
    frp_pkg::opcode_t     in_op_reg;
    frp_pkg::tick_t       in_tick_reg;
    logic                 out_valid_reg;
    logic                 out_grant_reg;

    frp_pkg::interval_t   interval_reg;
    logic                 limit_en_reg;

    frp_pkg::tick_t       last_tick_reg,  last_tick_next;
    logic                 tick_seen_reg,  tick_seen_next;
    frp_pkg::credit_t     credit_reg,     credit_next;
    logic                 grant_held_reg, grant_held_next;
    logic                 force_reg,      force_next;
    logic                 grant_next;

    logic                 advance;
    logic                 process;
    frp_pkg::sum_t        iv;
    frp_pkg::sum_t        cap;
    frp_pkg::tick_t       delta;
    frp_pkg::sum_t        sum;
    frp_pkg::sum_t        sum_capped;
    logic                 pace_ok;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(frp_pkg::OUT_DATA_BITS-1){1'b0}}, out_grant_reg};

    // Pacing datapath
    assign iv    = (interval_reg == '0) ? frp_pkg::UNIT_INTERVAL
                                        : frp_pkg::sum_t'(interval_reg);
    assign cap   = iv << frp_pkg::CAP_SHIFT;
    assign delta = in_tick_reg - last_tick_reg;
    assign sum   = frp_pkg::sum_t'(credit_reg)
                 + (frp_pkg::sum_t'(delta) << frp_pkg::FRAC_BITS);
    assign sum_capped = (sum > cap) ? cap : sum;
    assign pace_ok    = (sum_capped >= iv);

    always_comb
    begin
        last_tick_next  = last_tick_reg;
        tick_seen_next  = tick_seen_reg;
        credit_next     = credit_reg;
        grant_held_next = grant_held_reg;
        force_next      = force_reg;
        grant_next      = 1'b0;
        unique case (in_op_reg)
            frp_pkg::OP_BEGIN:
            begin
                priority if (grant_held_reg)
                begin
                    grant_next = 1'b1;
                end
                else if (force_reg)
                begin
                    force_next      = 1'b0;
                    grant_held_next = 1'b1;
                    grant_next      = 1'b1;
                end
                else if (!limit_en_reg)
                begin
                    grant_held_next = 1'b1;
                    grant_next      = 1'b1;
                end
                else if (!tick_seen_reg || delta[frp_pkg::TICK_BITS-1])
                begin
                    tick_seen_next  = 1'b1;
                    last_tick_next  = in_tick_reg;
                    credit_next     = frp_pkg::credit_t'(iv);
                    grant_held_next = 1'b1;
                    grant_next      = 1'b1;
                end
                else
                begin
                    last_tick_next = in_tick_reg;
                    if (pace_ok)
                    begin
                        credit_next     = frp_pkg::credit_t'(sum_capped - iv);
                        grant_held_next = 1'b1;
                        grant_next      = 1'b1;
                    end
                    else
                    begin
                        credit_next = frp_pkg::credit_t'(sum_capped);
                    end
                end
            end
            frp_pkg::OP_END:
            begin
                grant_held_next = 1'b0;
            end
            frp_pkg::OP_FORCE:
            begin
                force_next = 1'b1;
            end
            frp_pkg::OP_OPEN:
            begin
                last_tick_next  = '0;
                tick_seen_next  = 1'b0;
                credit_next     = '0;
                grant_held_next = 1'b0;
                force_next      = 1'b1;
            end
            frp_pkg::OP_CLOSE:
            begin
                grant_held_next = 1'b0;
                force_next      = 1'b0;
            end
            default:
            begin
                grant_next = 1'b0;
            end
        endcase
    end

    // Handshake and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            interval_reg   <= frp_pkg::FRAME_INTERVAL_RESET;
            limit_en_reg   <= 1'b1;
            last_tick_reg  <= '0;
            tick_seen_reg  <= 1'b0;
            credit_reg     <= '0;
            grant_held_reg <= 1'b0;
            force_reg      <= 1'b1;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    frp_pkg::REG_FRAME_INTERVAL: interval_reg <= cfg_wdata;
                    frp_pkg::REG_LIMIT_ENABLE:   limit_en_reg <= cfg_wdata[0];
                    default:                     limit_en_reg <= limit_en_reg;
                endcase
            end
            if (process)
            begin
                last_tick_reg  <= last_tick_next;
                tick_seen_reg  <= tick_seen_next;
                credit_reg     <= credit_next;
                grant_held_reg <= grant_held_next;
                force_reg      <= force_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= s_axis_tdata[frp_pkg::OP_BITS-1:0];
            in_tick_reg <= s_axis_tdata[frp_pkg::OP_BITS +: frp_pkg::TICK_BITS];
        end
        if (process)
        begin
            out_grant_reg <= grant_next;
        end
    end

endmodule

// File: design/frp_checker.sv
// ----------------------------------------------------------------------------
// frp_checker
// Port-level checks for the frame pacer, bound to the top level.
// ----------------------------------------------------------------------------
module frp_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [frp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    logic s_xfer;
    assign s_xfer = s_axis_tvalid && s_axis_tready;

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && !m_axis_tvalid) ##1 1'b1 |=> m_axis_tvalid)
        else $error("accepted transfer produced no result");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[frp_pkg::OUT_DATA_BITS-1:1] == '0))
        else $error("result padding not zero");

endmodule

bind frame_rate_pacer frp_checker u_frp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: verif/frp_grant_scoreboard.sv
// ----------------------------------------------------------------------------
// frp_grant_scoreboard
// Predicts render_granted for every event taken on s_axis from a local copy
// of the token-bucket state and the configuration. Compares each result taken
// on m_axis with the oldest prediction, and reports the failure count and the
// number of predictions still waiting.
// ----------------------------------------------------------------------------
module frp_grant_scoreboard
    import frp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    // [2:0] opcode, [34:3] now_tick, [39:35] zero
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,

    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [0] render_granted, [7:1] zero
    input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,

    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [INTERVAL_BITS-1:0] cfg_wdata,

    output int                       failures,
    output int                       outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    interval_t   frame_ticks;
    logic        pacing_on;
    tick_t       prev_tick;
    logic        tick_valid;
    logic [31:0] credit_level;
    logic        holding_grant;
    logic        force_armed;
    logic        expected_grants[$];

    function automatic logic bucket_admit(tick_t now);
        logic [63:0] iv;
        logic [63:0] cap;
        logic [63:0] total;
        tick_t       elapsed;
        iv = (frame_ticks == '0) ? 64'(UNIT_INTERVAL) : 64'(frame_ticks);
        cap = iv << CAP_SHIFT;
        if (!pacing_on)
            return 1'b1;
        elapsed = now - prev_tick;
        if (!tick_valid || elapsed[TICK_BITS-1])
        begin
            tick_valid = 1'b1;
            prev_tick = now;
            credit_level = 32'(iv);
            return 1'b1;
        end
        prev_tick = now;
        total = 64'(credit_level) + (64'(elapsed) << FRAC_BITS);
        if (total > cap)
            total = cap;
        if (total >= iv)
        begin
            credit_level = 32'(total - iv);
            return 1'b1;
        end
        credit_level = 32'(total);
        return 1'b0;
    endfunction

    function automatic logic predict_grant(opcode_t op, tick_t now);
        logic granted;
        granted = 1'b0;
        case (op)
            OP_BEGIN:
            begin
                if (holding_grant)
                    granted = 1'b1;
                else if (force_armed)
                begin
                    force_armed = 1'b0;
                    holding_grant = 1'b1;
                    granted = 1'b1;
                end
                else if (bucket_admit(now))
                begin
                    holding_grant = 1'b1;
                    granted = 1'b1;
                end
            end
            OP_END:
                holding_grant = 1'b0;
            OP_FORCE:
                force_armed = 1'b1;
            OP_OPEN:
            begin
                prev_tick = '0;
                tick_valid = 1'b0;
                credit_level = '0;
                holding_grant = 1'b0;
                force_armed = 1'b1;
            end
            OP_CLOSE:
            begin
                holding_grant = 1'b0;
                force_armed = 1'b0;
            end
            default:
                granted = 1'b0;
        endcase
        return granted;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        if (!rst_n)
        begin
            frame_ticks = FRAME_INTERVAL_RESET;
            pacing_on = 1'b1;
            prev_tick = '0;
            tick_valid = 1'b0;
            credit_level = '0;
            holding_grant = 1'b0;
            force_armed = 1'b1;
            expected_grants.delete();
            failures = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FRAME_INTERVAL: frame_ticks = cfg_wdata;
                    REG_LIMIT_ENABLE:   pacing_on = cfg_wdata[0];
                    default:            pacing_on = pacing_on;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("unexpected result transfer: render_granted %0d", m_axis_tdata[0]);
                    failures++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (m_axis_tdata[0] !== want)
                    begin
                        $error("render_granted mismatch: expected %0d, actual %0d",
                               want, m_axis_tdata[0]);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_grants.push_back(predict_grant(s_axis_tdata[OP_BITS-1:0],
                                                        s_axis_tdata[OP_BITS +: TICK_BITS]));
            outstanding = expected_grants.size();
        end
    end

endmodule

// File: verif/tb_frame_rate_pacer.sv
// ----------------------------------------------------------------------------
// tb_frame_rate_pacer
// Drives control events into the frame pacer: a directed run through the
// grant, force, open, close and tick-wrap cases, then random frame loops under
// several interval and pacing settings, with random gaps and back-pressure.
// A scoreboard beside the block checks every result and counts failures.
// ----------------------------------------------------------------------------
module tb_frame_rate_pacer;

    timeunit 1ns;
    timeprecision 1ps;

    import frp_pkg::*;

    localparam opcode_t OP_FIRST_UNUSED = 3'd5;
    localparam opcode_t OP_LAST_UNUSED  = 3'd7;
    localparam int      QUIET_LIMIT     = 2000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     cfg_wr_en;
    logic                     cfg_index;
    logic [INTERVAL_BITS-1:0] cfg_wdata;
    int                       failures;
    int                       outstanding;

    bit        gaps_on;
    interval_t pace_interval;
    tick_t     cur_tick;
    int        events_sent;
    int        quiet_cycles;

    frame_rate_pacer i_dut (.*);

    frp_grant_scoreboard i_grant_scoreboard (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_axis_tready <= gaps_on ? ($urandom_range(99) >= 35) : 1'b1;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_event(input opcode_t op, input tick_t now);
        while (gaps_on && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_BITS-OP_BITS-TICK_BITS){1'b0}}, now, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        events_sent++;
    endtask

    // Drop valid and wait until every result has been taken
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input interval_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input interval_t iv, input logic enable, input int count,
                             input bit gaps);
        int    stop_at;
        int    span;
        int    pick;
        settle();
        write_reg(REG_FRAME_INTERVAL, iv);
        write_reg(REG_LIMIT_ENABLE, interval_t'(enable));
        pace_interval = iv;
        gaps_on = gaps;
        cur_tick = $urandom;
        span = 2 * (int'(iv) >> FRAC_BITS) + 2;
        stop_at = events_sent + count;
        while (events_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                cur_tick = cur_tick + tick_t'($urandom_range(span));
                push_event(OP_BEGIN, cur_tick);
                if ($urandom_range(99) < 70)
                    push_event(OP_END, $urandom);
            end
            else if (pick < 65)
                push_event(OP_END, $urandom);
            else if (pick < 72)
                push_event(OP_FORCE, $urandom);
            else if (pick < 77)
                push_event(OP_OPEN, $urandom);
            else if (pick < 82)
                push_event(OP_CLOSE, $urandom);
            else if (pick < 85)
                push_event(opcode_t'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), $urandom);
            else if (pick < 92)
            begin
                cur_tick = cur_tick - tick_t'($urandom_range(1, 1000));
                push_event(OP_BEGIN, cur_tick);
            end
            else if (pick < 96)
            begin
                cur_tick = cur_tick + tick_t'($urandom_range(1000, 32'h7FFF_FFFF));
                push_event(OP_BEGIN, cur_tick);
            end
            else
            begin
                cur_tick = $urandom;
                push_event(OP_BEGIN, cur_tick);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_FRAME_INTERVAL;
        cfg_wdata = '0;
        gaps_on = 1'b1;
        pace_interval = FRAME_INTERVAL_RESET;
        cur_tick = '0;
        events_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Force after reset, held grant, first tick, credit build-up and refusal
        push_event(OP_BEGIN, 32'd0);
        push_event(OP_BEGIN, 32'd100);
        push_event(OP_END, 32'd0);
        push_event(OP_BEGIN, 32'd100);
        push_event(OP_END, 32'hFFFF_FFFF);
        push_event(OP_BEGIN, 32'd101);
        push_event(OP_END, 32'd0);
        push_event(OP_BEGIN, 32'd101);
        // Saturation, sign wrap of the elapsed time and a backward step
        push_event(OP_BEGIN, 32'h7FFF_FFFF);
        push_event(OP_END, 32'd0);
        push_event(OP_BEGIN, 32'h8000_0000);
        push_event(OP_END, 32'd0);
        push_event(OP_BEGIN, 32'h7FFF_FFFF);
        push_event(OP_END, 32'd0);
        push_event(OP_FORCE, 32'hFFFF_FFFF);
        push_event(OP_BEGIN, 32'h7FFF_FFFF);
        push_event(OP_CLOSE, 32'hFFFF_FFFF);
        push_event(OP_BEGIN, 32'h8000_0001);
        push_event(OP_OPEN, 32'hFFFF_FFFF);
        push_event(OP_BEGIN, 32'hFFFF_FFFF);
        push_event(OP_END, 32'd0);
        push_event(OP_BEGIN, 32'd0);
        for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
            push_event(opcode_t'(op), 32'hFFFF_FFFF);

        run_phase(FRAME_INTERVAL_RESET, 1'b1, 180, 1'b1);
        run_phase(24'h01_0000, 1'b1, 160, 1'b0);
        run_phase(24'd1, 1'b1, 150, 1'b1);
        run_phase(24'hFF_FFFF, 1'b1, 160, 1'b1);
        run_phase(24'd0, 1'b1, 140, 1'b1);
        run_phase(interval_t'($urandom_range(1, 24'hFF_FFFF)), 1'b0, 140, 1'b1);
        run_phase(interval_t'($urandom_range(1, 24'hFF_FFFF)), 1'b1, 170, 1'b1);
        run_phase(FRAME_INTERVAL_RESET, 1'b1, 50, 1'b1);

        settle();
        repeat (4) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
